// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property check on the rising edge, held off during reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// plain invariant, checked on every rising edge out of reset
`define ASSERT_INV(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_INV(lbl, clk, rstn, expr, msg)

`endif

`endif

// File: rtl/tnmq_pkg.sv
// ----------------------------------------------------------------------------
// tnmq_pkg
// shared types and constants of the timestamp nearest match queue
// ----------------------------------------------------------------------------
package tnmq_pkg;

    localparam int unsigned TIME_W    = 48;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned TOL_W     = 20;
    localparam int unsigned OUT_CNT_W = 7;
    localparam int unsigned CNT_SAT   = 127;

    localparam logic [TOL_W-1:0] TOL_RESET = 20'd10000;

    typedef enum logic {
        REQ_PUSH  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]    time_us;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic                 matched;
        logic [PAYLOAD_W-1:0] match_payload;
        logic [TIME_W-1:0]    match_time;
        logic [OUT_CNT_W-1:0] discarded;
        logic                 overflow;
        logic [OUT_CNT_W-1:0] occupancy;
    } result_t;

endpackage

// File: rtl/tnmq_mem.sv
// ----------------------------------------------------------------------------
// tnmq_mem
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tnmq_mem
    import tnmq_pkg::*;
#(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/timestamp_nearest_match_queue.sv
// ----------------------------------------------------------------------------
// timestamp_nearest_match_queue
// fifo of timestamped entries; a query drops stale heads and pops the first
// entry inside the +/- tolerance window
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   req_type, time_us, entry_payload
//  m_       out  m_valid / m_ready   matched, match_payload, match_time,
//                                    discarded, overflow, occupancy
//  cfg_     in   cfg_we              cfg_wdata (tolerance_us)
//
//  push, or query on an empty fifo: result registered at the transfer. other
//  query: walks the entries discarded, plus one when the walk ends on a match
//  or a newer head, one at a time through the single read port of the entry ram.
//  reset clears pointers, fill count and control, and loads the reset
//  tolerance; the ram is not cleared and only written entries are ever read.
//  a result waits in the output register; the next transfer is taken once
//  that register is empty or being emptied and no walk is running.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timestamp_nearest_match_queue
    import tnmq_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [TOL_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [TIME_W-1:0]    s_time_us,
    input  logic [PAYLOAD_W-1:0] s_entry_payload,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_matched,
    output logic [PAYLOAD_W-1:0] m_match_payload,
    output logic [TIME_W-1:0]    m_match_time,
    output logic [OUT_CNT_W-1:0] m_discarded,
    output logic                 m_overflow,
    output logic [OUT_CNT_W-1:0] m_occupancy
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] n);
        return (32'(n) > 32'(CNT_SAT)) ? OUT_CNT_W'(CNT_SAT) : OUT_CNT_W'(n);
    endfunction

    function automatic logic [OUT_CNT_W-1:0] sat_inc(input logic [OUT_CNT_W-1:0] n);
        return (n == OUT_CNT_W'(CNT_SAT)) ? n : n + OUT_CNT_W'(1);
    endfunction

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TOL_W-1:0]     tol_reg;
    logic [TIME_W:0]      hi_reg, hi_next;
    logic [TIME_W-1:0]    lo_reg, lo_next;
    logic                 lo_ok_reg, lo_ok_next;
    logic [OUT_CNT_W-1:0] disc_reg, disc_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              res_reg, res_next;

    logic       in_acc, is_query, full, out_free;
    logic       newer, stale, walk_done;
    logic       wr_en, rd_en;
    logic [PTR_W-1:0] rd_addr;
    entry_t     wr_data, rd_data;

    tnmq_mem #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_valid && s_ready;
    assign is_query = (s_req_type == REQ_QUERY);
    assign full     = (cnt_reg == CNT_FULL);

    assign wr_data.time_us = s_time_us;
    assign wr_data.payload = s_entry_payload;

    // window bounds were formed at the query transfer
    assign newer     = {1'b0, rd_data.time_us} > hi_reg;
    assign stale     = lo_ok_reg && (rd_data.time_us < lo_reg);
    assign walk_done = newer || !stale || (cnt_reg == CNT_ONE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && is_query && (cnt_reg != '0)) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        lo_ok_next   = lo_ok_reg;
        disc_next    = disc_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = head_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && !is_query) begin
                    wr_en = !full;
                    if (!full) begin
                        tail_next = ptr_inc(tail_reg);
                        cnt_next  = cnt_reg + CNT_ONE;
                    end
                    res_next           = '0;
                    res_next.overflow  = full;
                    res_next.occupancy = sat_cnt(full ? cnt_reg : cnt_reg + CNT_ONE);
                    m_valid_next       = 1'b1;
                end else if (in_acc) begin
                    disc_next  = '0;
                    hi_next    = {1'b0, s_time_us} + (TIME_W + 1)'(tol_reg);
                    lo_ok_next = s_time_us >= TIME_W'(tol_reg);
                    lo_next    = s_time_us - TIME_W'(tol_reg);
                    if (cnt_reg == '0) begin
                        res_next           = '0;
                        res_next.occupancy = sat_cnt(cnt_reg);
                        m_valid_next       = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = head_reg;
                    end
                end
            end
            ST_WALK: begin
                // fetch the following entry ahead in case this one is stale
                rd_en   = 1'b1;
                rd_addr = ptr_inc(head_reg);
                if (!newer) begin
                    head_next = ptr_inc(head_reg);
                    cnt_next  = cnt_reg - CNT_ONE;
                    if (stale) begin
                        disc_next = sat_inc(disc_reg);
                    end
                end
                if (walk_done) begin
                    res_next.matched       = !newer && !stale;
                    res_next.match_payload = (!newer && !stale) ? rd_data.payload : '0;
                    res_next.match_time    = (!newer && !stale) ? rd_data.time_us : '0;
                    res_next.discarded     = (!newer && stale) ? sat_inc(disc_reg)
                                                               : disc_reg;
                    res_next.overflow      = 1'b0;
                    res_next.occupancy     = sat_cnt(newer ? cnt_reg : cnt_reg - CNT_ONE);
                    m_valid_next           = 1'b1;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            tol_reg     <= TOL_RESET;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        lo_ok_reg <= lo_ok_next;
        disc_reg  <= disc_next;
        res_reg   <= res_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_matched       = res_reg.matched;
    assign m_match_payload = res_reg.match_payload;
    assign m_match_time    = res_reg.match_time;
    assign m_discarded     = res_reg.discarded;
    assign m_overflow      = res_reg.overflow;
    assign m_occupancy     = res_reg.occupancy;

    `ASSERT_INV(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_FULL, "fill count above depth")
    `ASSERT_PROP(a_walk_nonempty, aclk, aresetn, (state_reg == ST_WALK) |-> (cnt_reg != '0), "walk on empty fifo")
    `ASSERT_PROP(a_walk_out_free, aclk, aresetn, (state_reg == ST_WALK) |-> !m_valid_reg, "walk with result pending")
    `ASSERT_PROP(a_push_count, aclk, aresetn, (in_acc && !is_query && !full) |=> (cnt_reg == CNT_W'($past(cnt_reg) + CNT_ONE)), "push did not grow fifo")

endmodule

// File: tb/sv/timestamp_nearest_match_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamp_nearest_match_queue_tb
// Drives pushes and queries with random gaps and stalls on both channels.
// A scoreboard keeps its own copy of the entry fifo and the tolerance. It
// predicts every result when an input transfer is accepted and checks each
// output transfer field by field.
// ----------------------------------------------------------------------------
module timestamp_nearest_match_queue_tb;
    import tnmq_pkg::*;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 125;
    localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

    class match_scoreboard;
        entry_t                pose_entries[$];
        result_t               expected_results[$];
        logic [TOL_W-1:0]      tolerance;
        int unsigned           error_count;
        int unsigned           result_count;

        function new();
            tolerance    = TOL_RESET;
            error_count  = 0;
            result_count = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function logic [OUT_CNT_W-1:0] sat_count(int unsigned n);
            return (n > CNT_SAT) ? OUT_CNT_W'(CNT_SAT) : OUT_CNT_W'(n);
        endfunction

        function result_t predict_match(req_t req, logic [TIME_W-1:0] t,
                                        logic [PAYLOAD_W-1:0] pay);
            result_t     r;
            entry_t      head;
            entry_t      fresh;
            logic [63:0] head_t;
            logic [63:0] img_t;
            logic [63:0] tol;
            int unsigned stale;
            bit          done;
            r     = '0;
            stale = 0;
            done  = 0;
            img_t = 64'(t);
            tol   = 64'(tolerance);
            if (req == REQ_PUSH) begin
                if (pose_entries.size() >= DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    fresh.time_us = t;
                    fresh.payload = pay;
                    pose_entries  = {pose_entries, fresh};
                end
            end else begin
                while (!done && pose_entries.size() > 0) begin
                    head   = pose_entries[0];
                    head_t = 64'(head.time_us);
                    // 64-bit sums, so the window never wraps
                    if (head_t > img_t + tol) begin
                        done = 1;
                    end else begin
                        pose_entries.delete(0);
                        if (head_t + tol < img_t) begin
                            stale++;
                        end else begin
                            r.matched       = 1'b1;
                            r.match_payload = head.payload;
                            r.match_time    = head.time_us;
                            done = 1;
                        end
                    end
                end
            end
            r.discarded = sat_count(stale);
            r.occupancy = sat_count(pose_entries.size());
            return r;
        endfunction

        function void note_transfer(req_t req, logic [TIME_W-1:0] t,
                                    logic [PAYLOAD_W-1:0] pay);
            expected_results = {expected_results, predict_match(req, t, pay)};
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("ERROR result %0d %s: got %0h want %0h",
                     result_count, what, got, want);
            error_count++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("with nothing expected", got.match_payload, 64'(0));
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got.matched !== want.matched)
                    report_mismatch("matched", 64'(got.matched), 64'(want.matched));
                if (got.match_payload !== want.match_payload)
                    report_mismatch("match_payload", got.match_payload,
                                    want.match_payload);
                if (got.match_time !== want.match_time)
                    report_mismatch("match_time", 64'(got.match_time),
                                    64'(want.match_time));
                if (got.discarded !== want.discarded)
                    report_mismatch("discarded", 64'(got.discarded),
                                    64'(want.discarded));
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
                if (got.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 64'(got.occupancy),
                                    64'(want.occupancy));
            end
            result_count++;
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [TOL_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_req_type;
    logic [TIME_W-1:0]    s_time_us;
    logic [PAYLOAD_W-1:0] s_entry_payload;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_matched;
    logic [PAYLOAD_W-1:0] m_match_payload;
    logic [TIME_W-1:0]    m_match_time;
    logic [OUT_CNT_W-1:0] m_discarded;
    logic                 m_overflow;
    logic [OUT_CNT_W-1:0] m_occupancy;

    match_scoreboard   board;
    bit                no_idle       = 0;
    bit                hold_request  = 0;
    int unsigned       items_sent    = 0;
    int unsigned       idle_cycles   = 0;
    logic [TIME_W-1:0] recent_pushes[$];

    always #4 aclk = ~aclk;

    timestamp_nearest_match_queue #(
        .FIFO_DEPTH(DEPTH)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_time_us       (s_time_us),
        .s_entry_payload (s_entry_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_matched       (m_matched),
        .m_match_payload (m_match_payload),
        .m_match_time    (m_match_time),
        .m_discarded     (m_discarded),
        .m_overflow      (m_overflow),
        .m_occupancy     (m_occupancy)
    );

    // watchdog: ends the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (aresetn !== 1'b1) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        result_t     got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.matched       = m_matched;
            got.match_payload = m_match_payload;
            got.match_time    = m_match_time;
            got.discarded     = m_discarded;
            got.overflow      = m_overflow;
            got.occupancy     = m_occupancy;
            board.check_result(got);
        end
    end

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_item(req_t req, logic [TIME_W-1:0] t, logic [PAYLOAD_W-1:0] pay);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_time_us       <= t;
        s_entry_payload <= pay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_transfer(req, t, pay);
        if (req == REQ_PUSH) begin
            recent_pushes = {recent_pushes, t};
            if (recent_pushes.size() > 8)
                recent_pushes.delete(0);
        end
        items_sent++;
    endtask

    // must be called in the step of the last input transfer
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] value);
        drain();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.tolerance = value;
    endtask

    task automatic run_phase(bit flood_first);
        int unsigned kind;
        int unsigned span;
        int unsigned n;
        logic [63:0] cursor;
        logic [63:0] anchor;
        logic [63:0] qt;
        logic [63:0] tol;
        logic [63:0] flood_start;
        int unsigned phase_end;
        phase_end = items_sent + PHASE_ITEMS;
        tol    = 64'(board.tolerance);
        span   = board.tolerance + 1;
        cursor = 64'($urandom_range(0, 1000000));
        while (items_sent < phase_end) begin
            kind = flood_first ? 0 : $urandom_range(0, 99);
            flood_first = 0;
            if (kind < 7) begin
                // fill past the depth, then one query at the top time, the last push time or the flood start
                n = DEPTH + $urandom_range(1, 3);
                flood_start = cursor;
                repeat (n) begin
                    cursor = cursor + 64'($urandom_range(0, span));
                    send_item(REQ_PUSH, TIME_W'(cursor), {$urandom, $urandom});
                end
                case ($urandom_range(0, 2))
                    0:       qt = 64'(MAX_TIME);
                    1:       qt = cursor;
                    default: qt = flood_start;
                endcase
                send_item(REQ_QUERY, TIME_W'(qt), {$urandom, $urandom});
            end else if (kind < 17) begin
                repeat ($urandom_range(1, 3))
                    send_item(($urandom_range(0, 1) == 0) ? REQ_PUSH : REQ_QUERY,
                              TIME_W'({$urandom, $urandom}), {$urandom, $urandom});
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    cursor = cursor + 64'($urandom_range(0, 2 * span));
                    send_item(REQ_PUSH, TIME_W'(cursor), {$urandom, $urandom});
                end
                repeat ($urandom_range(1, 3)) begin
                    anchor = 64'(recent_pushes[$urandom_range(0, recent_pushes.size() - 1)]);
                    case ($urandom_range(0, 5))
                        0: qt = anchor + tol;
                        1: qt = (anchor >= tol) ? anchor - tol : 64'(0);
                        2: qt = anchor + tol + 64'(1);
                        3: qt = (anchor > tol) ? anchor - tol - 64'(1) : anchor;
                        default: begin
                            qt = anchor + 64'($urandom_range(0, 4 * span));
                            qt = (qt >= 64'(2 * span)) ? qt - 64'(2 * span) : 64'(0);
                        end
                    endcase
                    send_item(REQ_QUERY, TIME_W'(qt), {$urandom, $urandom});
                end
            end
        end
    endtask

    initial begin
        s_valid         = 1'b0;
        s_req_type      = REQ_PUSH;
        s_time_us       = '0;
        s_entry_payload = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = TOL_RESET;
        aresetn         = 1'b0;
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, at the reset tolerance of 10000
        send_item(REQ_QUERY, 0, '0);                        // empty fifo
        send_item(REQ_PUSH, 0, '0);
        send_item(REQ_PUSH, 20000, '1);
        send_item(REQ_QUERY, 10000, '0);                    // lower window edge
        send_item(REQ_QUERY, 10000, '1);                    // upper window edge
        send_item(REQ_PUSH, 5, 64'h5555_5555_5555_5555);
        send_item(REQ_PUSH, 30000, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(REQ_QUERY, 20000, '0);                    // one stale, then edge
        send_item(REQ_PUSH, 100000, 64'h0123_4567_89AB_CDEF);
        send_item(REQ_QUERY, 50000, '0);                    // head newer, kept
        send_item(REQ_QUERY, 110001, '0);                   // stale by one, empties
        send_item(REQ_PUSH, 3, 64'hFEDC_BA98_7654_3210);
        send_item(REQ_QUERY, 2, '0);                        // window below zero
        send_item(REQ_PUSH, MAX_TIME, 64'h8000_0000_0000_0001);
        send_item(REQ_PUSH, MAX_TIME - 1, 64'h7FFF_FFFF_FFFF_FFFE);
        send_item(REQ_PUSH, 0, 64'hDEAD_BEEF_0000_FFFF);
        send_item(REQ_QUERY, MAX_TIME - 10001, '0);         // just below the head
        send_item(REQ_QUERY, MAX_TIME, '0);                 // top of the time range
        send_item(REQ_QUERY, 0, '0);
        send_item(REQ_QUERY, MAX_TIME, '1);
        send_item(REQ_QUERY, 10001, '0);

        run_phase(1);
        set_tolerance(0);
        run_phase(0);
        set_tolerance(1000000);
        hold_request = 1;
        run_phase(0);
        set_tolerance({TOL_W{1'b1}});
        no_idle = 1;
        run_phase(0);
        no_idle = 0;
        set_tolerance(1);
        run_phase(0);
        set_tolerance(TOL_W'($urandom_range(2, 50000)));
        run_phase(0);

        drain();
        repeat (20) @(posedge aclk);
        if (board.error_count == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
